@@ hdl/lkv_pkg.sv @@
`timescale 1ns / 1ps

package lkv_pkg;

   // Table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W  = IDX_W;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // Item field widths
   localparam int KEY_W   = 16;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
   localparam logic signed [VALUE_W-1:0] MISS_VALUE = -VALUE_W'(1);

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } command_type;

   typedef struct packed {
      command_type               command;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] read_value;
   } rsp_type;

   // Result of the parallel compare over all entries
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [RANK_W-1:0] hit_rank;
      logic [IDX_W-1:0]  free_idx;
      logic [IDX_W-1:0]  victim_idx;
   } match_type;

   // Occupancy seen by the top level
   typedef struct packed {
      logic [ENTRIES-1:0] valid;
      logic [CNT_W-1:0]   count;
   } status_type;

endpackage

@@ hdl/lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps

// Fully associative key/value cache, least recently used replacement.
// Request channel (req_valid, req_stall, req_data): a get looks up a key,
// a put updates a present key or inserts it, evicting the least recent
// entry once the entry count has reached the capacity.
// Response channel (rsp_valid, rsp_stall, rsp_data): one item per get,
// carrying found and the stored value (-1 on a miss); puts give none.
// Config channel (csr_valid, csr_ready, csr_data): writes the capacity,
// 0 acts as 1 and values above the table depth act as the depth. Write it
// only while no request is in flight.
// A get is held in the request register, looked up from there, and its
// result is registered in the response register.
// Throughput: one request per cycle while req_stall is low; the compare
// over all entries and the recency update run from the request register.
// Reset empties the table and sets the capacity to 16; no clearing pass.
// A stalled response holds; a following get then waits in the request
// register and req_stall rises, while puts keep flowing.
module lru_key_value_cache_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lkv_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lkv_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0]   csr_data
);
   import lkv_pkg::*;

   logic             in_valid_ff, in_valid_in;
   req_type          in_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_item_ff;
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] eff_cap;
   logic             process;
   logic             is_get;
   rsp_type          table_rsp;
   status_type       status;

   lkv_table u_table (
      .clock   (clock),
      .reset   (reset),
      .apply   (process),
      .req     (in_item_ff),
      .eff_cap (eff_cap),
      .rsp     (table_rsp),
      .status  (status)
   );

   // Capacity register
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (int'(capacity_ff) > ENTRIES) begin
         eff_cap = CNT_W'(ENTRIES);
      end else begin
         eff_cap = CNT_W'(capacity_ff);
      end
   end

   // Process the held item unless a get would overrun a stalled response
   assign is_get    = (in_item_ff.command == CMD_GET);
   assign process   = in_valid_ff && (!is_get || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !process;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = (process && is_get) ? 1'b1 :
                         (rsp_stall ? rsp_valid_ff : 1'b0);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         capacity_ff  <= capacity_in;
      end
   end

   // Load the request register on accept, the response register on a get
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
      if (process && is_get) begin
         rsp_item_ff <= table_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   // Request side stalls only behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("request stalled without a held response");

   // Every processed get shows a response next cycle
   a_get_response: assert property (@(posedge clock) disable iff (reset)
      (process && is_get) |=> rsp_valid)
      else $error("processed get gave no response");

   // Entry count tracks the valid bits
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(status.valid) == int'(status.count))
      else $error("entry count differs from valid bits");

   // A stalled get blocks a new response from overwriting the held one
   a_hold_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("held response changed");

endmodule

@@ hdl/lkv_match.sv @@
`timescale 1ns / 1ps

module lkv_match (
   input  logic [lkv_pkg::ENTRIES-1:0]                     valid,
   input  logic [lkv_pkg::ENTRIES-1:0][lkv_pkg::KEY_W-1:0]  keys,
   input  logic [lkv_pkg::ENTRIES-1:0][lkv_pkg::RANK_W-1:0] ranks,
   input  logic [lkv_pkg::CNT_W-1:0]                       count,
   input  logic [lkv_pkg::KEY_W-1:0]                       key,
   output lkv_pkg::match_type                              match
);
   import lkv_pkg::*;

   logic [CNT_W-1:0] last_rank;

   // Oldest valid entry carries rank count-1
   assign last_rank = count - CNT_W'(1);

   // Compare every entry at once; the lowest index wins each search
   always_comb begin
      match = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid[i] && keys[i] == key) begin
            match.hit      = 1'b1;
            match.hit_idx  = IDX_W'(i);
            match.hit_rank = ranks[i];
         end
         if (!valid[i]) begin
            match.free_idx = IDX_W'(i);
         end
         if (valid[i] && CNT_W'(ranks[i]) == last_rank) begin
            match.victim_idx = IDX_W'(i);
         end
      end
   end

endmodule

@@ hdl/lkv_table.sv @@
`timescale 1ns / 1ps

module lkv_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       apply,
   input  lkv_pkg::req_type           req,
   input  logic [lkv_pkg::CNT_W-1:0]  eff_cap,
   output lkv_pkg::rsp_type           rsp,
   output lkv_pkg::status_type        status
);
   import lkv_pkg::*;

   logic [ENTRIES-1:0]                   valid_ff, valid_in;
   logic [ENTRIES-1:0][KEY_W-1:0]        key_ff;
   logic [ENTRIES-1:0][VALUE_W-1:0]      value_ff;
   logic [ENTRIES-1:0][RANK_W-1:0]       rank_ff, rank_in;
   logic [CNT_W-1:0]                     count_ff, count_in;

   match_type        match;
   logic             is_put;
   logic             do_insert;
   logic             do_ranks;
   logic             do_write;
   logic [IDX_W-1:0] target;
   logic [CNT_W-1:0] threshold;

   lkv_match u_match (
      .valid (valid_ff),
      .keys  (key_ff),
      .ranks (rank_ff),
      .count (count_ff),
      .key   (req.key),
      .match (match)
   );

   assign is_put = (req.command == CMD_PUT);

   // Pick the slot to touch and the rank below which entries age
   always_comb begin
      do_insert = 1'b0;
      do_ranks  = 1'b0;
      do_write  = 1'b0;
      target    = match.hit_idx;
      threshold = CNT_W'(match.hit_rank);
      if (match.hit) begin
         do_ranks = 1'b1;
         do_write = is_put;
      end else if (is_put) begin
         do_ranks = 1'b1;
         do_write = 1'b1;
         if (count_ff < eff_cap) begin
            do_insert = 1'b1;
            target    = match.free_idx;
            threshold = count_ff;
         end else begin
            target    = match.victim_idx;
            threshold = count_ff - CNT_W'(1);
         end
      end
   end

   // Age the more recent entries and make the target the most recent
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      count_in = count_ff;
      if (apply && do_ranks) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && CNT_W'(rank_ff[i]) < threshold) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         rank_in[target] = '0;
      end
      if (apply && do_insert) begin
         valid_in[target] = 1'b1;
         count_in         = count_ff + CNT_W'(1);
      end
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rank_ff  <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         count_ff <= count_in;
      end
   end

   // Store key and value of a put
   always_ff @(posedge clock) begin
      if (apply && do_write) begin
         key_ff[target]   <= req.key;
         value_ff[target] <= req.value;
      end
   end

   // Form the lookup result
   always_comb begin
      rsp.found      = match.hit;
      rsp.read_value = match.hit ? signed'(value_ff[match.hit_idx]) : MISS_VALUE;
   end

   assign status.valid = valid_ff;
   assign status.count = count_ff;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import lkv_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int PHASES       = 10;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_WAIT     = 4;
   localparam int PRINT_LIMIT  = 40;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data;

   lru_key_value_cache_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Shadow copy of the cache table
   logic               line_used  [ENTRIES];
   logic [KEY_W-1:0]   line_key   [ENTRIES];
   logic [VALUE_W-1:0] line_value [ENTRIES];
   int unsigned        line_age   [ENTRIES];
   int unsigned        line_count;
   logic [CAP_W-1:0]   cap_setting;

   // Lookup results still owed by the block, oldest first
   rsp_type pending_reads[$];

   int  mismatch_count;
   int  reads_checked;
   int  hits_seen;
   int  gets_sent;
   int  puts_sent;
   int  cap_writes;
   int  cycle_count;
   bit  idle_on;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d lookups outstanding", cycle_count,
               pending_reads.size());
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int draw_wait();
      return idle_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
   endfunction

   // Capacity as the block applies it: zero acts as one, saturate at the depth
   function automatic int unsigned cap_limit();
      if (cap_setting == 0) return 1;
      if (cap_setting > ENTRIES) return ENTRIES;
      return cap_setting;
   endfunction

   function automatic void table_clear();
      int i;
      for (i = 0; i < ENTRIES; i++) begin
         line_used[i]  = 1'b0;
         line_key[i]   = '0;
         line_value[i] = '0;
         line_age[i]   = 0;
      end
      line_count  = 0;
      cap_setting = CAP_RESET;
   endfunction

   // Move one line to the front; lines ahead of it age by one
   function automatic void make_newest(int s);
      int i;
      int unsigned r;
      r = line_age[s];
      for (i = 0; i < ENTRIES; i++)
         if (line_used[i] && line_age[i] < r) line_age[i]++;
      line_age[s] = 0;
   endfunction

   function automatic int find_line(logic [KEY_W-1:0] k);
      int i;
      for (i = 0; i < ENTRIES; i++)
         if (line_used[i] && line_key[i] == k) return i;
      return -1;
   endfunction

   // Apply one accepted request to the shadow table; queue the lookup result
   function automatic void lru_apply(req_type item);
      int      s;
      int      slot;
      int      i;
      rsp_type want;
      s = find_line(item.key);
      if (item.command == CMD_GET) begin
         want.found      = (s >= 0);
         want.read_value = (s >= 0) ? line_value[s] : MISS_VALUE;
         if (s >= 0) make_newest(s);
         pending_reads.push_back(want);
         return;
      end
      // Update in place, nothing evicted
      if (s >= 0) begin
         line_value[s] = item.value;
         make_newest(s);
         return;
      end
      slot = -1;
      if (line_count < cap_limit()) begin
         // Insert into the lowest free line
         for (i = 0; i < ENTRIES; i++)
            if (!line_used[i] && slot < 0) slot = i;
         for (i = 0; i < ENTRIES; i++)
            if (line_used[i]) line_age[i]++;
         line_used[slot]  = 1'b1;
         line_key[slot]   = item.key;
         line_value[slot] = item.value;
         line_age[slot]   = 0;
         line_count++;
      end else begin
         // Replace the least recent line
         for (i = 0; i < ENTRIES; i++)
            if (line_used[i] && (slot < 0 || line_age[i] > line_age[slot])) slot = i;
         line_key[slot]   = item.key;
         line_value[slot] = item.value;
         make_newest(slot);
      end
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_read(rsp_type got);
      rsp_type want;
      if (pending_reads.size() == 0) begin
         report_mismatch($sformatf("unexpected item found=%b read_value=%0d",
                                   got.found, got.read_value));
         return;
      end
      want = pending_reads.pop_front();
      reads_checked++;
      if (got.found !== want.found)
         report_mismatch($sformatf("lookup %0d: found %b, want %b",
                                   reads_checked, got.found, want.found));
      if (got.read_value !== want.read_value)
         report_mismatch($sformatf("lookup %0d: read_value %0d, want %0d",
                                   reads_checked, got.read_value, want.read_value));
      if (want.found) hits_seen++;
   endtask

   // Response side: check each item, then stall a random number of cycles
   initial begin : rsp_side
      int hold;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            check_read(rsp_data);
            hold = draw_wait();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one request; return at the edge that accepts it
   task automatic send_item(command_type cmd, logic [KEY_W-1:0] k,
                            logic [VALUE_W-1:0] v);
      int      gap;
      req_type item;
      item.command = cmd;
      item.key     = k;
      item.value   = v;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      lru_apply(item);
      if (cmd == CMD_GET) gets_sent++;
      else puts_sent++;
   endtask

   // Drop valid, drain all lookups, then let trailing puts finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] c);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= c;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      cap_setting = c;
      cap_writes++;
   endtask

   // Key extremes, value extremes, update in place, get of an absent key
   task automatic test_basic_access();
      send_item(CMD_GET, 16'h0000, 32'h0000_0000);
      send_item(CMD_PUT, 16'h0000, 32'h7FFF_FFFF);
      send_item(CMD_PUT, 16'hFFFF, 32'h8000_0000);
      send_item(CMD_GET, 16'h0000, 32'hFFFF_FFFF);
      send_item(CMD_GET, 16'hFFFF, 32'h0000_0000);
      send_item(CMD_PUT, 16'h0000, 32'hFFFF_FFFF);
      send_item(CMD_GET, 16'h0000, 32'h1234_5678);
      send_item(CMD_GET, 16'h1234, 32'h5555_AAAA);
   endtask

   // Capacity zero acts as one and sits below the count: surplus stays
   task automatic test_capacity_floor();
      write_capacity(5'd0);
      send_item(CMD_PUT, 16'h0100, 32'h0000_0001);
      send_item(CMD_GET, 16'hFFFF, 32'h0000_0000);
      send_item(CMD_GET, 16'h0000, 32'h0000_0000);
      send_item(CMD_PUT, 16'h0200, 32'h0000_0002);
      send_item(CMD_GET, 16'h0100, 32'h0000_0000);
      send_item(CMD_GET, 16'h0200, 32'h0000_0000);
   endtask

   // Capacity equal to the count: a new key evicts the oldest line
   task automatic test_eviction_order();
      write_capacity(5'd2);
      send_item(CMD_GET, 16'h0200, 32'h0000_0000);
      send_item(CMD_PUT, 16'h0300, 32'h0000_0003);
      send_item(CMD_GET, 16'h0000, 32'h0000_0000);
      send_item(CMD_GET, 16'h0300, 32'h0000_0000);
   endtask

   task automatic random_item(logic [KEY_W-1:0] base, int span);
      int                 pick;
      logic [KEY_W-1:0]   k;
      logic [VALUE_W-1:0] v;
      command_type        cmd;
      cmd  = ($urandom_range(0, 1) == 1) ? CMD_PUT : CMD_GET;
      pick = $urandom_range(0, 99);
      // Mostly keys from a pool a little larger than the capacity
      if (pick < 88) k = base + KEY_W'($urandom_range(0, span - 1));
      else k = KEY_W'($urandom);
      case ($urandom_range(0, 15))
         0:       v = 32'h0000_0000;
         1:       v = 32'hFFFF_FFFF;
         2:       v = 32'h7FFF_FFFF;
         3:       v = 32'h8000_0000;
         default: v = $urandom;
      endcase
      send_item(cmd, k, v);
   endtask

   // Random traffic over a run of capacity settings, table carried across
   task automatic test_random_traffic();
      logic [CAP_W-1:0] caps [PHASES];
      logic [KEY_W-1:0] base;
      int               span;
      int               p;
      caps = '{5'd31, 5'd3, 5'd16, 5'd1, 5'd0, 5'd17, 5'd8, 5'd0, 5'd2, 5'd20};
      caps[7] = CAP_W'($urandom_range(0, 31));
      for (p = 0; p < PHASES; p++) begin
         write_capacity(caps[p]);
         idle_on = (p % 3 != 2);
         base    = KEY_W'($urandom);
         span    = cap_limit() + $urandom_range(1, 6);
         repeat (RANDOM_ITEMS / PHASES) random_item(base, span);
      end
      idle_on = 1'b1;
   endtask

   initial begin : main
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      csr_valid      <= 1'b0;
      csr_data       <= '0;
      mismatch_count = 0;
      reads_checked  = 0;
      hits_seen      = 0;
      gets_sent      = 0;
      puts_sent      = 0;
      cap_writes     = 0;
      idle_on        = 1'b1;
      table_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_basic_access();
      test_capacity_floor();
      test_eviction_order();
      test_random_traffic();
      settle();

      $display("covered %0d gets (%0d hits, %0d misses) and %0d puts", gets_sent,
               hits_seen, reads_checked - hits_seen, puts_sent);
      $display("over %0d capacity settings, zero and saturating values included",
               cap_writes);
      if (mismatch_count == 0 && pending_reads.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
